// ----- sv/glrle_pkg.sv -----
// shared types and constants for the grid layer run-length decoder
// no dependencies; used by glrle_ctrl, glrle_dp and grid_layer_rle_decoder
package glrle_pkg;

    // fixed field widths
    localparam int BYTE_W    = 8;
    localparam int COORD_W   = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int LEN_W     = 6;
    localparam int RUN_W     = 7;

    // default largest side of the layer
    localparam int MAX_SIDE_DEF = 1024;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 1'b1;

    // configuration reset values
    localparam logic [CFG_W-1:0] CFG_SIDE_RESET = 11'd256;

    // command byte opcodes (bits 7..6)
    localparam logic [1:0] OP_COPY = 2'b01;
    localparam logic [1:0] OP_FILL = 2'b10;

    // longest run, coded as length zero
    localparam logic [RUN_W-1:0] RUN_MAX = 7'd64;

    // controller to datapath
    typedef struct packed {
        logic load;   // input beat accepted this cycle
        logic emit;   // write one cell into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic go_emit;    // the beat being accepted produces cells
        logic emit_last;  // the cell being emitted ends the run
        logic out_free;   // output register can take a cell this cycle
    } t_dp_status;

endpackage

// ----- sv/glrle_ctrl.sv -----
// controller state machine of the grid layer run-length decoder
// depends on glrle_pkg for the command and status structs
module glrle_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  glrle_pkg::t_dp_status i_status,
    output glrle_pkg::t_dp_cmd    o_cmd,
    output logic                  o_ready
);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_ready    = (r_state == S_IDLE);
    assign o_cmd.load = (r_state == S_IDLE) && i_valid;
    assign o_cmd.emit = (r_state == S_EMIT) && i_status.out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && i_status.go_emit) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free && i_status.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/glrle_dp.sv -----
// datapath of the grid layer run-length decoder: position, phase, run count,
// configuration and output register; depends on glrle_pkg
module glrle_dp #(
    parameter int MAX_SIDE = glrle_pkg::MAX_SIDE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  glrle_pkg::t_dp_cmd                  i_cmd,
    output glrle_pkg::t_dp_status               o_status,
    input  logic [glrle_pkg::BYTE_W-1:0]        i_stream_byte,
    input  logic                                i_layer_start,
    input  logic                                i_cfg_we,
    input  logic [glrle_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [glrle_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                                i_ready,
    output logic                                o_valid,
    output logic [glrle_pkg::COORD_W-1:0]       o_cell_x,
    output logic [glrle_pkg::COORD_W-1:0]       o_cell_y,
    output logic [glrle_pkg::BYTE_W-1:0]        o_cell_value,
    output logic                                o_run_last,
    output logic                                o_layer_done
);

    localparam int POS_W = $clog2(MAX_SIDE + 1);
    localparam int CMP_W = (POS_W > glrle_pkg::CFG_W) ? POS_W : glrle_pkg::CFG_W;
    localparam logic [CMP_W-1:0] MAX_X = CMP_W'(MAX_SIDE);

    typedef enum logic [1:0] {
        PH_CMD  = 2'd0,
        PH_COPY = 2'd1,
        PH_FILL = 2'd2
    } t_phase;

    // configuration
    logic [glrle_pkg::CFG_W-1:0] r_cfg_w;
    logic [glrle_pkg::CFG_W-1:0] r_cfg_h;

    // decoder state
    logic [POS_W-1:0]            r_col, n_col;
    logic [POS_W-1:0]            r_row, n_row;
    t_phase                      r_phase, n_phase;
    logic [glrle_pkg::RUN_W-1:0] r_run, n_run;
    logic                        r_fin, n_fin;
    logic [glrle_pkg::RUN_W-1:0] r_cnt, n_cnt;
    logic [glrle_pkg::BYTE_W-1:0] r_val, n_val;

    // output register
    logic                          r_out_valid;
    logic [glrle_pkg::COORD_W-1:0] r_x;
    logic [glrle_pkg::COORD_W-1:0] r_y;
    logic [glrle_pkg::BYTE_W-1:0]  r_v;
    logic                          r_last;
    logic                          r_done;

    logic [CMP_W-1:0] cfg_w_x, cfg_h_x, eff_w, eff_h;
    logic [CMP_W-1:0] col_x, row_x;

    // accept-side values
    logic [POS_W-1:0]            col0, row0;
    t_phase                      phase0;
    logic [glrle_pkg::RUN_W-1:0] run0, fill_n, cmd_len, copy_run;
    logic                        fin0, fin1;
    logic [1:0]                  op;
    logic                        go_emit;

    // emit-side values
    logic [POS_W-1:0] col_inc, e_col, e_row;
    logic             wrap, e_done, e_last;

    // effective width and height: width 0 acts as 1, both saturate to MAX_SIDE
    always_comb begin
        cfg_w_x = CMP_W'(r_cfg_w);
        cfg_h_x = CMP_W'(r_cfg_h);
        eff_w   = (cfg_w_x == '0) ? CMP_W'(1) : cfg_w_x;
        if (eff_w > MAX_X) begin
            eff_w = MAX_X;
        end
        eff_h = (cfg_h_x > MAX_X) ? MAX_X : cfg_h_x;
    end

    // layer start clears position and phase before the byte is looked at
    always_comb begin
        col0    = i_layer_start ? '0 : r_col;
        row0    = i_layer_start ? '0 : r_row;
        phase0  = i_layer_start ? PH_CMD : r_phase;
        run0    = i_layer_start ? '0 : r_run;
        fin0    = i_layer_start ? 1'b0 : r_fin;
        fin1    = fin0 || (CMP_W'(row0) >= eff_h);
        op      = i_stream_byte[glrle_pkg::BYTE_W-1 -: 2];
        cmd_len = (i_stream_byte[glrle_pkg::LEN_W-1:0] == '0) ? glrle_pkg::RUN_MAX
                : {1'b0, i_stream_byte[glrle_pkg::LEN_W-1:0]};
        fill_n  = (run0 > glrle_pkg::RUN_MAX) ? glrle_pkg::RUN_MAX : run0;
        copy_run = (run0 != '0) ? run0 - 1'b1 : run0;
        go_emit = 1'b0;
        if (!fin1) begin
            case (phase0)
                PH_COPY: go_emit = 1'b1;
                PH_FILL: go_emit = (fill_n != '0);
                default: go_emit = 1'b0;
            endcase
        end
    end

    // one cell: advance column, wrap into next row, check for layer end
    always_comb begin
        col_inc = r_col + 1'b1;
        wrap    = (CMP_W'(col_inc) >= eff_w);
        e_col   = wrap ? '0 : col_inc;
        e_row   = wrap ? r_row + 1'b1 : r_row;
        e_done  = (CMP_W'(e_row) >= eff_h);
        e_last  = e_done || (r_cnt == glrle_pkg::RUN_W'(1));
        col_x   = CMP_W'(r_col);
        row_x   = CMP_W'(r_row);
    end

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_phase = r_phase;
        n_run   = r_run;
        n_fin   = r_fin;
        n_cnt   = r_cnt;
        n_val   = r_val;
        if (i_cmd.load) begin
            n_col   = col0;
            n_row   = row0;
            n_phase = phase0;
            n_run   = run0;
            n_fin   = fin1;
            n_val   = i_stream_byte;
            if (!fin1) begin
                case (phase0)
                    PH_COPY: begin
                        n_cnt   = glrle_pkg::RUN_W'(1);
                        n_run   = copy_run;
                        n_phase = (copy_run == '0) ? PH_CMD : PH_COPY;
                    end
                    PH_FILL: begin
                        n_cnt   = fill_n;
                        n_run   = '0;
                        n_phase = PH_CMD;
                    end
                    default: begin
                        // command byte, unused phase code acts the same
                        if (op == glrle_pkg::OP_COPY) begin
                            n_phase = PH_COPY;
                            n_run   = cmd_len;
                        end else if (op == glrle_pkg::OP_FILL) begin
                            n_phase = PH_FILL;
                            n_run   = cmd_len;
                        end else begin
                            n_phase = PH_CMD;
                            n_run   = '0;
                        end
                    end
                endcase
            end
        end else if (i_cmd.emit) begin
            n_col = e_col;
            n_row = e_row;
            n_cnt = r_cnt - 1'b1;
            if (e_done) begin
                n_fin = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= glrle_pkg::CFG_SIDE_RESET;
            r_cfg_h     <= glrle_pkg::CFG_SIDE_RESET;
            r_col       <= '0;
            r_row       <= '0;
            r_phase     <= PH_CMD;
            r_run       <= '0;
            r_fin       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    glrle_pkg::CFG_MAP_WIDTH:  r_cfg_w <= i_cfg_data;
                    glrle_pkg::CFG_MAP_HEIGHT: r_cfg_h <= i_cfg_data;
                    default: ;
                endcase
            end
            r_col   <= n_col;
            r_row   <= n_row;
            r_phase <= n_phase;
            r_run   <= n_run;
            r_fin   <= n_fin;
            r_cnt   <= n_cnt;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        if (i_cmd.emit) begin
            r_x    <= col_x[glrle_pkg::COORD_W-1:0];
            r_y    <= row_x[glrle_pkg::COORD_W-1:0];
            r_v    <= r_val;
            r_last <= e_last;
            r_done <= e_done;
        end
    end

    assign o_status.go_emit   = go_emit;
    assign o_status.emit_last = e_last;
    assign o_status.out_free  = !r_out_valid || i_ready;

    assign o_valid      = r_out_valid;
    assign o_cell_x     = r_x;
    assign o_cell_y     = r_y;
    assign o_cell_value = r_v;
    assign o_run_last   = r_last;
    assign o_layer_done = r_done;

endmodule

// ----- sv/grid_layer_rle_decoder.sv -----
// top level of the grid layer run-length decoder
// depends on glrle_pkg, glrle_ctrl and glrle_dp
//
// Decodes one grid layer from a run-length byte stream taken one byte per input
// beat and writes cells in raster order on the output channel. A command byte
// carries a 2-bit opcode in bits 7..6 and a run length in bits 5..0 (0 means 64):
// copy (01) turns each of the next run bytes into one cell, fill (10) repeats the
// next byte over the run, the other opcodes produce nothing. layer_start on a
// beat clears position, phase and done before that byte is decoded. Decoding
// stops when the row reaches map_height; layer_done marks that cell, and later
// bytes are dropped until the next layer_start. A command byte, or any byte
// after the layer is done, is only accepted; a copy data byte is accepted, then
// one cell goes into the output register; a fill data byte is accepted, then
// its cells follow, up to 64. The fill is emitted by a single cell register and
// position counter, one cell per cycle while the output register is free, and
// output back-pressure holds it. A finished cell waits in the output register
// while the next byte is already accepted. Write map_width (index 0) and
// map_height (index 1) only while the block is idle.
module grid_layer_rle_decoder #(
    parameter int MAX_SIDE = glrle_pkg::MAX_SIDE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input byte channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [glrle_pkg::BYTE_W-1:0]        i_stream_byte,
    input  logic                                i_layer_start,
    // output cell channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [glrle_pkg::COORD_W-1:0]       o_cell_x,
    output logic [glrle_pkg::COORD_W-1:0]       o_cell_y,
    output logic [glrle_pkg::BYTE_W-1:0]        o_cell_value,
    output logic                                o_run_last,
    output logic                                o_layer_done,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [glrle_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [glrle_pkg::CFG_W-1:0]         i_cfg_data
);

    glrle_pkg::t_dp_cmd    dp_cmd;
    glrle_pkg::t_dp_status dp_status;

    // controller: idle takes a beat, emit sends one cell per free output slot
    glrle_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_ready  (o_ready)
    );

    // datapath: decoder state, position counters and output register
    glrle_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_stream_byte (i_stream_byte),
        .i_layer_start (i_layer_start),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_cell_x      (o_cell_x),
        .o_cell_y      (o_cell_y),
        .o_cell_value  (o_cell_value),
        .o_run_last    (o_run_last),
        .o_layer_done  (o_layer_done)
    );

endmodule
